### design/erpd_pkg.sv
// shared types and constants of the escape-coded run-length page decoder
`default_nettype none
package erpd_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLIPPED = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam int OFFSET_W = 16;
  localparam int LENGTH_W = 17;

  typedef struct packed {
    logic [OFFSET_W-1:0] fill_offset;
    logic [LENGTH_W-1:0] fill_length;
    logic [7:0]          fill_value;
    logic                page_done;
    logic [1:0]          status;
  } result_t;

endpackage
`default_nettype wire

### design/erpd_if.sv
// channel interfaces for packed input bytes and fill commands
`default_nettype none
interface erpd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] packed_byte;
  logic       last;

  modport source (output valid, output op, output packed_byte, output last, input ready);
  modport sink (input valid, input op, input packed_byte, input last, output ready);
endinterface

interface erpd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fill_offset;
  logic [16:0] fill_length;
  logic [7:0]  fill_value;
  logic        page_done;
  logic [1:0]  status;

  modport source (output valid, output fill_offset, output fill_length, output fill_value,
                  output page_done, output status, input ready);
  modport sink (input valid, input fill_offset, input fill_length, input fill_value,
                input page_done, input status, output ready);
endinterface
`default_nettype wire

### design/erpd_core.sv
// decoder state and per-byte decode into a fill command
`default_nettype none
module erpd_core #(
  parameter int PAGE_BYTES = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic             op,
  input  wire logic [7:0]       packed_byte,
  input  wire logic             last,
  output logic                  res_valid,
  output erpd_pkg::result_t     res
);

  localparam int OFF_W = $clog2(PAGE_BYTES + 1);
  localparam int LEN_W = erpd_pkg::LENGTH_W;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_DATA  = 3'd1,
    PH_VALUE = 3'd2,
    PH_COUNT = 3'd3,
    PH_CLO   = 3'd4,
    PH_CHI   = 3'd5
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        escape_r, escape_nxt;
  logic [7:0]        run_value_r, run_value_nxt;
  logic [7:0]        count_low_r, count_low_nxt;
  logic [OFF_W-1:0]  wr_off_r, wr_off_nxt;
  logic              overrun_r, overrun_nxt;

  logic              do_run;
  logic              seq_open;
  logic [15:0]       run_n;
  logic [7:0]        run_val;
  logic [OFF_W-1:0]  room;
  logic              clipped;
  logic              skip;
  logic [LEN_W-1:0]  run_len;
  logic [LEN_W-1:0]  wr_len;

  always_comb begin
    phase_nxt     = phase_r;
    escape_nxt    = escape_r;
    run_value_nxt = run_value_r;
    count_low_nxt = count_low_r;
    wr_off_nxt    = wr_off_r;
    overrun_nxt   = overrun_r;
    res_valid     = 1'b0;
    res           = '0;
    do_run        = 1'b0;
    seq_open      = 1'b0;
    run_n         = 16'd1;
    run_val       = run_value_r;

    if (op) begin
      phase_nxt       = PH_FIRST;
      wr_off_nxt      = '0;
      overrun_nxt     = 1'b0;
      res_valid       = 1'b1;
      res.fill_length = LEN_W'(PAGE_BYTES);
      res.page_done   = 1'b1;
      res.status      = erpd_pkg::ST_OK;
    end else begin
      case (phase_r)
        PH_DATA: begin
          if (packed_byte == escape_r) begin
            phase_nxt = PH_VALUE;
            seq_open  = 1'b1;
          end else begin
            run_val       = packed_byte;
            run_value_nxt = packed_byte;
            run_n         = 16'd1;
            do_run        = 1'b1;
          end
        end
        PH_VALUE: begin
          run_value_nxt = packed_byte;
          phase_nxt     = PH_COUNT;
          seq_open      = 1'b1;
        end
        PH_COUNT: begin
          if (packed_byte != 8'd0) begin
            run_n  = {8'd0, packed_byte};
            do_run = 1'b1;
          end else begin
            phase_nxt = PH_CLO;
            seq_open  = 1'b1;
          end
        end
        PH_CLO: begin
          count_low_nxt = packed_byte;
          phase_nxt     = PH_CHI;
          seq_open      = 1'b1;
        end
        PH_CHI: begin
          run_n  = {packed_byte, count_low_r};
          do_run = 1'b1;
        end
        default: begin
          // first byte: escape code and background of the whole page
          escape_nxt      = packed_byte;
          run_value_nxt   = packed_byte;
          count_low_nxt   = 8'd0;
          wr_off_nxt      = '0;
          overrun_nxt     = 1'b0;
          phase_nxt       = last ? PH_FIRST : PH_DATA;
          res_valid       = 1'b1;
          res.fill_length = LEN_W'(PAGE_BYTES);
          res.fill_value  = packed_byte;
          res.page_done   = last;
          res.status      = erpd_pkg::ST_OK;
        end
      endcase
    end

    // run arithmetic, clipped against the page end
    room    = OFF_W'(PAGE_BYTES) - wr_off_r;
    clipped = {1'b0, run_n} > LEN_W'(room);
    run_len = clipped ? LEN_W'(room) : {1'b0, run_n};
    skip    = (run_val == escape_r);
    wr_len  = skip ? '0 : run_len;

    if (do_run) begin
      overrun_nxt = overrun_r | clipped;
      wr_off_nxt  = wr_off_r + OFF_W'(run_len);
      phase_nxt   = last ? PH_FIRST : PH_DATA;
      if (last || !(skip || run_n == 16'd0)) begin
        res_valid       = 1'b1;
        res.fill_length = wr_len;
        res.fill_offset = (wr_len != '0) ? erpd_pkg::OFFSET_W'(wr_off_r) : '0;
        res.fill_value  = (wr_len != '0) ? run_val : 8'd0;
        res.page_done   = last;
        if (last)
          res.status = overrun_nxt ? erpd_pkg::ST_CLIPPED : erpd_pkg::ST_OK;
        else
          res.status = clipped ? erpd_pkg::ST_CLIPPED : erpd_pkg::ST_OK;
      end
    end

    // page ends inside an escape sequence
    if (seq_open && last) begin
      phase_nxt     = PH_FIRST;
      res_valid     = 1'b1;
      res           = '0;
      res.page_done = 1'b1;
      res.status    = erpd_pkg::ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      escape_r    <= 8'd0;
      run_value_r <= 8'd0;
      count_low_r <= 8'd0;
      wr_off_r    <= '0;
      overrun_r   <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      escape_r    <= escape_nxt;
      run_value_r <= run_value_nxt;
      count_low_r <= count_low_nxt;
      wr_off_r    <= wr_off_nxt;
      overrun_r   <= overrun_nxt;
    end
  end

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_off_r <= OFF_W'(PAGE_BYTES))
    else $error("write offset passed page end");

  a_empty_page_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op |=> wr_off_r == '0 && !overrun_r && phase_r == PH_FIRST)
    else $error("empty page did not restart the page");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_CHI)
    else $error("phase left the defined codes");

endmodule
`default_nettype wire

### design/escape_rle_page_decoder.sv
// top level: input register, decode core and result register
// an accepted byte is held in the input register, then decoded by the core into the result register
// throughput: one packed byte per cycle while no result waits on a stalled output, the decode is a single pass per byte
// while a result waits the input register still takes one byte, then input stalls
// reset (rst_n low, synchronous) empties both stages and awaits a page's first byte
`default_nettype none
module escape_rle_page_decoder #(
  parameter int PAGE_BYTES = 65536
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  erpd_in_if.sink     in_ch,
  erpd_out_if.source  out_ch
);

  logic              s1_valid_r;
  logic              s1_op_r;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic              advance;
  logic              in_fire;
  logic              core_valid;
  erpd_pkg::result_t core_res;
  logic              out_valid_r;
  erpd_pkg::result_t out_res_r;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_ch.op;
      s1_byte_r <= in_ch.packed_byte;
      s1_last_r <= in_ch.last;
    end
  end

  erpd_core #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .op         (s1_op_r),
    .packed_byte(s1_byte_r),
    .last       (s1_last_r),
    .res_valid  (core_valid),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && core_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.fill_offset = out_res_r.fill_offset;
  assign out_ch.fill_length = out_res_r.fill_length;
  assign out_ch.fill_value  = out_res_r.fill_value;
  assign out_ch.page_done   = out_res_r.page_done;
  assign out_ch.status      = out_res_r.status;

  a_fill_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_res_r.fill_offset} + out_res_r.fill_length
                     <= 17'(PAGE_BYTES)))
    else $error("fill command reaches past page end");

  a_no_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.fill_length == '0 |->
      out_res_r.fill_offset == '0 && out_res_r.fill_value == 8'd0)
    else $error("empty fill carries offset or value");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire

### tb/escape_rle_page_decoder_test.sv
// self-checking testbench for the escape-coded run-length page decoder
`timescale 1ns / 1ps
module escape_rle_page_decoder_test;

  localparam int PAGE_BYTES  = 65536;
  localparam int CLK_PERIOD  = 20;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 8;

  typedef enum logic [2:0] {
    WAIT_FIRST,
    WAIT_DATA,
    WAIT_VALUE,
    WAIT_COUNT,
    WAIT_COUNT_LO,
    WAIT_COUNT_HI
  } decode_phase_t;

  logic clk = 1'b0;
  logic rst_n;

  erpd_in_if  in_ch ();
  erpd_out_if out_ch ();

  escape_rle_page_decoder #(.PAGE_BYTES(PAGE_BYTES)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder shadow state
  decode_phase_t dec_phase;
  logic [7:0]    dec_escape;
  logic [7:0]    dec_value;
  logic [7:0]    dec_count_lo;
  logic [16:0]   dec_offset;
  logic          dec_overrun;

  erpd_pkg::result_t fills_due[$];
  logic [7:0]        page_buf[$];

  int src_idle_pct;
  int sink_idle_pct;
  int errors;
  int items_sent;
  int fills_checked;
  int pages_closed;
  int clipped_fills;
  int truncated_pages;
  int stall_cycles;

  function automatic bit decode_run(input int n, input bit last,
                                    output erpd_pkg::result_t r);
    int off;
    int room;
    int len;
    bit skip;
    bit clipped;
    r = '0;
    off = int'(dec_offset);
    room = (off < PAGE_BYTES) ? PAGE_BYTES - off : 0;
    skip = (dec_value == dec_escape);
    clipped = (n > room);
    len = clipped ? room : n;
    if (clipped) dec_overrun = 1'b1;
    dec_offset = 17'(off + len);
    dec_phase = last ? WAIT_FIRST : WAIT_DATA;
    // skips and empty runs only move the offset and the overrun flag unless they close the page
    if (!last && (skip || n == 0)) return 1'b0;
    if (skip) len = 0;
    r.fill_offset = (len != 0) ? 16'(off) : '0;
    r.fill_length = 17'(len);
    r.fill_value  = (len != 0) ? dec_value : '0;
    r.page_done   = last;
    if (last) r.status = dec_overrun ? erpd_pkg::ST_CLIPPED : erpd_pkg::ST_OK;
    else r.status = clipped ? erpd_pkg::ST_CLIPPED : erpd_pkg::ST_OK;
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic op, input logic [7:0] b, input logic last,
                                     output erpd_pkg::result_t r);
    r = '0;
    if (op) begin
      dec_phase = WAIT_FIRST;
      dec_offset = '0;
      dec_overrun = 1'b0;
      r.fill_length = 17'(PAGE_BYTES);
      r.page_done = 1'b1;
      r.status = erpd_pkg::ST_OK;
      return 1'b1;
    end
    case (dec_phase)
      WAIT_DATA: begin
        if (b == dec_escape) begin
          dec_phase = WAIT_VALUE;
        end else begin
          dec_value = b;
          return decode_run(1, last, r);
        end
      end
      WAIT_VALUE: begin
        dec_value = b;
        dec_phase = WAIT_COUNT;
      end
      WAIT_COUNT: begin
        if (b != 8'h00) return decode_run(int'(b), last, r);
        dec_phase = WAIT_COUNT_LO;
      end
      WAIT_COUNT_LO: begin
        dec_count_lo = b;
        dec_phase = WAIT_COUNT_HI;
      end
      WAIT_COUNT_HI: begin
        return decode_run(int'({b, dec_count_lo}), last, r);
      end
      default: begin
        // first byte of a page: escape code and background in one
        dec_escape = b;
        dec_value = b;
        dec_count_lo = '0;
        dec_offset = '0;
        dec_overrun = 1'b0;
        dec_phase = last ? WAIT_FIRST : WAIT_DATA;
        r.fill_length = 17'(PAGE_BYTES);
        r.fill_value = b;
        r.page_done = last;
        r.status = erpd_pkg::ST_OK;
        return 1'b1;
      end
    endcase
    // escape sequence still open
    if (!last) return 1'b0;
    dec_phase = WAIT_FIRST;
    r.page_done = 1'b1;
    r.status = erpd_pkg::ST_TRUNC;
    return 1'b1;
  endfunction

  task automatic flag_field(input string field, input int want, input int got);
    $display("%0t mismatch in %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    errors++;
  endtask

  // predict on input transactions, check output transactions, watch for stalls
  always @(posedge clk) begin
    erpd_pkg::result_t want;
    erpd_pkg::result_t got;
    bit                busy;
    if (!rst_n) begin
      dec_phase    = WAIT_FIRST;
      dec_escape   = '0;
      dec_value    = '0;
      dec_count_lo = '0;
      dec_offset   = '0;
      dec_overrun  = 1'b0;
    end else begin
      busy = 1'b0;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        busy = 1'b1;
        if (decode_byte(in_ch.op, in_ch.packed_byte, in_ch.last, want))
          fills_due.push_back(want);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        busy = 1'b1;
        got.fill_offset = out_ch.fill_offset;
        got.fill_length = out_ch.fill_length;
        got.fill_value  = out_ch.fill_value;
        got.page_done   = out_ch.page_done;
        got.status      = out_ch.status;
        if (fills_due.size() == 0) begin
          $display("%0t unexpected fill command: offset 0x%0h length 0x%0h value 0x%0h done %0b status %0d",
                   $time, got.fill_offset, got.fill_length, got.fill_value, got.page_done,
                   got.status);
          errors++;
        end else begin
          want = fills_due.pop_front();
          fills_checked++;
          if (want.page_done) pages_closed++;
          if (want.status == erpd_pkg::ST_CLIPPED) clipped_fills++;
          if (want.status == erpd_pkg::ST_TRUNC) truncated_pages++;
          if (got.fill_offset !== want.fill_offset)
            flag_field("fill_offset", int'(want.fill_offset), int'(got.fill_offset));
          if (got.fill_length !== want.fill_length)
            flag_field("fill_length", int'(want.fill_length), int'(got.fill_length));
          if (got.fill_value !== want.fill_value)
            flag_field("fill_value", int'(want.fill_value), int'(got.fill_value));
          if (got.page_done !== want.page_done)
            flag_field("page_done", int'(want.page_done), int'(got.page_done));
          if (got.status !== want.status)
            flag_field("status", int'(want.status), int'(got.status));
        end
      end
      if (busy) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t no transaction for %0d cycles, %0d fills outstanding",
                   $time, STALL_LIMIT, fills_due.size());
          $display("escape_rle_page_decoder verification failed");
          $finish;
        end
      end
    end
  end

  // fill command receiver with random back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_item(input logic op, input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.packed_byte <= b;
    in_ch.last        <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_page_buf(input bit close);
    for (int i = 0; i < page_buf.size(); i++)
      send_item(1'b0, page_buf[i], close && (i == page_buf.size() - 1));
  endtask

  // sender holds off until every predicted fill has come out
  task automatic wait_all_fills();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (fills_due.size() != 0);
  endtask

  function automatic logic [7:0] pick_literal(input logic [7:0] esc);
    logic [7:0] b;
    do b = 8'($urandom); while (b == esc);
    return b;
  endfunction

  // one page covering literals, runs, skips, long counts and clipping
  task automatic test_directed_page();
    page_buf = '{8'hAA, 8'h00,
                 8'hAA, 8'h55, 8'h03,
                 8'hAA, 8'hAA, 8'h10,
                 8'hAA, 8'h77, 8'h00, 8'h00, 8'h00,
                 8'hAA, 8'h11, 8'h00, 8'hFF, 8'hFF,
                 8'h42,
                 8'hAA, 8'hAA, 8'h05};
    send_page_buf(1'b1);
  endtask

  // empty page op, one-byte page and a page cut inside an escape
  task automatic test_short_pages();
    send_item(1'b1, 8'hFF, 1'b1);
    page_buf = '{8'hFF};
    send_page_buf(1'b1);
    page_buf = '{8'h00, 8'h00};
    send_page_buf(1'b1);
  endtask

  task automatic send_random_page();
    logic [7:0] esc;
    logic [7:0] val;
    logic [7:0] lo;
    logic [7:0] hi;
    int tokens;
    int pick;
    esc = 8'($urandom);
    tokens = $urandom_range(0, 10);
    page_buf = {};
    page_buf.push_back(esc);
    repeat (tokens) begin
      if ($urandom_range(99) < 55) begin
        page_buf.push_back(pick_literal(esc));
      end else begin
        val = ($urandom_range(3) == 0) ? esc : 8'($urandom);
        page_buf.push_back(esc);
        page_buf.push_back(val);
        if ($urandom_range(99) < 60) begin
          page_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
          pick = $urandom_range(9);
          if (pick < 2) {hi, lo} = 16'h0000;
          else if (pick < 6) {hi, lo} = 16'($urandom_range(1, 600));
          else {hi, lo} = 16'($urandom);
          page_buf.push_back(8'h00);
          page_buf.push_back(lo);
          page_buf.push_back(hi);
        end
      end
    end
    pick = $urandom_range(99);
    if (pick < 76) begin
      send_page_buf(1'b1);
    end else if (pick < 88) begin
      // close the page partway through an escape sequence
      pick = $urandom_range(1, 4);
      page_buf.push_back(esc);
      if (pick > 1) page_buf.push_back(8'($urandom));
      if (pick > 2) page_buf.push_back(8'h00);
      if (pick > 3) page_buf.push_back(8'($urandom));
      send_page_buf(1'b1);
    end else if (pick < 95) begin
      send_page_buf(1'b0);
      send_item(1'b1, 8'($urandom), 1'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) send_item(1'b0, 8'($urandom), $urandom_range(99) < 20);
    end
  endtask

  task automatic test_random_traffic(input int goal);
    int stop_at;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 4) send_item(1'b1, 8'($urandom), 1'($urandom));
      else send_random_page();
      if ($urandom_range(99) < 6) wait_all_fills();
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    fills_checked = 0;
    pages_closed = 0;
    clipped_fills = 0;
    truncated_pages = 0;
    stall_cycles = 0;
    src_idle_pct = 19;
    sink_idle_pct = 78;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= 1'b0;
    in_ch.packed_byte <= '0;
    in_ch.last        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_page();
    test_short_pages();
    test_random_traffic(120);
    wait_all_fills();
    src_idle_pct = 78;
    sink_idle_pct = 19;
    test_random_traffic(130);
    wait_all_fills();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(140);

    wait_all_fills();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d packed bytes and empty-page ops, checked %0d fill commands",
             items_sent, fills_checked);
    $display("%0d pages closed, %0d clipped results, %0d truncated escapes",
             pages_closed, clipped_fills, truncated_pages);
    if (errors == 0) begin
      $display("escape_rle_page_decoder verification clean");
    end else begin
      $display("escape_rle_page_decoder verification failed");
    end
    $finish;
  end

endmodule
